// ----- hw/rtl/slt_pkg.sv -----
// shared types, constants and arithmetic helpers of the scanline line tracker
package slt_pkg;

  // scanline geometry
  localparam int unsigned LINE_WIDTH = 320;
  localparam int unsigned COL_W      = 9;
  localparam int unsigned PIX_W      = 8;

  // result and datapath widths
  localparam int unsigned ERR_W   = 10;
  localparam int unsigned DIFF_W  = 11;
  localparam int unsigned GAIN_W  = 10;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned PROD_W  = DIFF_W + GAIN_W + 1;
  localparam int unsigned ACC_W   = 24;
  localparam int unsigned STEER_W = ACC_W - 8;
  localparam int unsigned ARG_W   = STEER_W + 1;
  localparam int unsigned MOTOR_W = 9;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;

  // error saturation and motor limits
  localparam logic signed [DIFF_W-1:0]  ERR_LIMIT   = 11'sd320;
  localparam logic signed [ARG_W-1:0]   DRIVE_LIMIT = 17'sd254;
  localparam logic signed [MOTOR_W-1:0] MOTOR_TOP   = 9'sd254;

  // configuration reset values
  localparam logic [PIX_W-1:0]   THR_RST     = 8'd127;
  localparam logic [COL_W-1:0]   MINLEN_RST  = 9'd20;
  localparam logic [COL_W-1:0]   CENTER_RST  = 9'd160;
  localparam logic [SPEED_W-1:0] BASE_RST    = 8'd140;
  localparam logic [SPEED_W-1:0] REV_RST     = 8'd64;
  localparam logic [GAIN_W-1:0]  PGAIN_RST   = 10'd128;
  localparam logic [GAIN_W-1:0]  DGAIN_RST   = 10'd51;
  localparam logic [GAIN_W-1:0]  RGAIN_RST   = 10'd256;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BW_THRESHOLD   = 3'd0,
    CFG_MIN_RUN_LENGTH = 3'd1,
    CFG_CENTER_COLUMN  = 3'd2,
    CFG_BASE_SPEED     = 3'd3,
    CFG_REVERSE_SPEED  = 3'd4,
    CFG_P_GAIN         = 3'd5,
    CFG_D_GAIN         = 3'd6,
    CFG_REVERSE_GAIN   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0]   bw_threshold;
    logic [COL_W-1:0]   min_run_length;
    logic [COL_W-1:0]   center_column;
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] reverse_speed;
    logic [GAIN_W-1:0]  p_gain;
    logic [GAIN_W-1:0]  d_gain;
    logic [GAIN_W-1:0]  reverse_gain;
  } cfg_t;

  // one finished scanline handed from the tracker to the steering unit
  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] start_col;
    logic [COL_W-1:0] end_col;
  } line_rec_t;

  // steering sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_FINISH
  } back_state_e;

  // divide by 256 rounding toward zero
  function automatic logic signed [STEER_W-1:0] trunc_div256(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] biased;
    begin
      biased = v + (v[ACC_W-1] ? 24'sd255 : 24'sd0);
      return biased[ACC_W-1:8];
    end
  endfunction

  // clamp to the drive range and convert to the motor command
  function automatic logic signed [MOTOR_W-1:0] motor_conv(input logic signed [ARG_W-1:0] v);
    logic signed [MOTOR_W-1:0] c;
    begin
      if (v > DRIVE_LIMIT) begin
        c = MOTOR_TOP;
      end else if (v < -DRIVE_LIMIT) begin
        c = -MOTOR_TOP;
      end else begin
        c = v[MOTOR_W-1:0];
      end
      if (!c[MOTOR_W-1]) begin
        return MOTOR_TOP - c;
      end else begin
        return -c - MOTOR_TOP;
      end
    end
  endfunction

endpackage

// ----- hw/rtl/slt_pix_if.sv -----
// pixel channel interface
interface slt_pix_if;
  import slt_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             end_of_line;

  modport source (output valid, output pixel_value, output end_of_line, input ready);
  modport sink   (input valid, input pixel_value, input end_of_line, output ready);
endinterface

// ----- hw/rtl/slt_res_if.sv -----
// result channel interface
interface slt_res_if;
  import slt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      line_found;
  logic [COL_W-1:0]          run_start;
  logic [COL_W-1:0]          run_end;
  logic [COL_W-1:0]          run_width;
  logic signed [ERR_W-1:0]   line_error;
  logic signed [MOTOR_W-1:0] left_motor;
  logic signed [MOTOR_W-1:0] right_motor;

  modport source (output valid, output line_found, output run_start, output run_end,
                  output run_width, output line_error, output left_motor,
                  output right_motor, input ready);
  modport sink   (input valid, input line_found, input run_start, input run_end,
                  input run_width, input line_error, input left_motor,
                  input right_motor, output ready);
endinterface

// ----- hw/rtl/scanline_line_tracker_pd_steer_core.sv -----
// top level of the scanline line tracker with pd steering
//
//   channel   dir  beat contents                                   handshake
//   pix_in    in   pixel_value, end_of_line                        valid/ready
//   res_out   out  line_found, run_start, run_end, run_width,      valid/ready
//                  line_error, left_motor, right_motor
//   cfg       in   cfg_idx_i, cfg_data_i                           cfg_we_i
//
// pixels are taken one per clock while the two-entry line queue has room.
// each end-of-line beat gives one result: the steering sequencer takes it through idle,
// mul1, mul2 (line found only) and finish, bound by its single shared multiplier.
// lines that come faster than the sequencer retires them back up the queue and then
// hold pixel ready low. a stalled result holds in the output register and stops the sequencer.
// reset clears line state, last valid error and loads the default configuration.
module scanline_line_tracker_pd_steer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  slt_pix_if.sink                       pix_in,
  slt_res_if.source                     res_out,
  input  logic                          cfg_we_i,
  input  logic [slt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [slt_pkg::CFG_W-1:0]     cfg_data_i
);
  import slt_pkg::*;

  cfg_t      cfg_q;
  line_rec_t push_rec;
  line_rec_t head_rec;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bw_threshold   <= THR_RST;
      cfg_q.min_run_length <= MINLEN_RST;
      cfg_q.center_column  <= CENTER_RST;
      cfg_q.base_speed     <= BASE_RST;
      cfg_q.reverse_speed  <= REV_RST;
      cfg_q.p_gain         <= PGAIN_RST;
      cfg_q.d_gain         <= DGAIN_RST;
      cfg_q.reverse_gain   <= RGAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BW_THRESHOLD:   cfg_q.bw_threshold   <= cfg_data_i[PIX_W-1:0];
        CFG_MIN_RUN_LENGTH: cfg_q.min_run_length <= cfg_data_i[COL_W-1:0];
        CFG_CENTER_COLUMN:  cfg_q.center_column  <= cfg_data_i[COL_W-1:0];
        CFG_BASE_SPEED:     cfg_q.base_speed     <= cfg_data_i[SPEED_W-1:0];
        CFG_REVERSE_SPEED:  cfg_q.reverse_speed  <= cfg_data_i[SPEED_W-1:0];
        CFG_P_GAIN:         cfg_q.p_gain         <= cfg_data_i[GAIN_W-1:0];
        CFG_D_GAIN:         cfg_q.d_gain         <= cfg_data_i[GAIN_W-1:0];
        CFG_REVERSE_GAIN:   cfg_q.reverse_gain   <= cfg_data_i[GAIN_W-1:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  // run tracker
  slt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_in (pix_in),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .rec_o  (push_rec)
  );

  // line queue
  slt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .rec_o   (head_rec)
  );

  // steering unit
  slt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .rec_i   (head_rec),
    .pop_o   (pop),
    .res_out (res_out)
  );

endmodule

// ----- hw/rtl/slt_front.sv -----
// run tracker: thresholds pixels and finds the first qualifying white run of a line
module slt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  slt_pix_if.sink           pix_in,
  input  slt_pkg::cfg_t     cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output slt_pkg::line_rec_t rec_o
);
  import slt_pkg::*;

  logic [COL_W-1:0] col_q, col_d;
  logic             inw_q, inw_d;
  logic [COL_W-1:0] start_q, start_d;
  logic [COL_W-1:0] end_q, end_d;
  logic             lock_q, lock_d;
  logic             accept;
  logic             white;

  assign pix_in.ready = !full_i;
  assign accept       = pix_in.valid && pix_in.ready;
  assign white        = pix_in.pixel_value >= cfg_i.bw_threshold;

  // run tracking for one pixel
  always_comb begin
    col_d   = col_q;
    inw_d   = inw_q;
    start_d = start_q;
    end_d   = end_q;
    lock_d  = lock_q;
    if (col_q < COL_W'(LINE_WIDTH)) begin
      if (!lock_q) begin
        if (white && !inw_q) begin
          inw_d   = 1'b1;
          start_d = col_q;
        end else if (!white && inw_q) begin
          end_d = col_q;
          if ((col_q - start_q) > cfg_i.min_run_length) begin
            lock_d = 1'b1;
          end else begin
            inw_d = 1'b0;
          end
        end
      end
      col_d = col_q + 1'b1;
    end
  end

  // line record on the last pixel
  assign push_o          = accept && pix_in.end_of_line;
  assign rec_o.found     = lock_d;
  assign rec_o.start_col = start_d;
  assign rec_o.end_col   = end_d;

  // per-line state, cleared after the last pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      inw_q   <= 1'b0;
      start_q <= '0;
      end_q   <= '0;
      lock_q  <= 1'b0;
    end else if (accept) begin
      if (pix_in.end_of_line) begin
        col_q   <= '0;
        inw_q   <= 1'b0;
        start_q <= '0;
        end_q   <= '0;
        lock_q  <= 1'b0;
      end else begin
        col_q   <= col_d;
        inw_q   <= inw_d;
        start_q <= start_d;
        end_q   <= end_d;
        lock_q  <= lock_d;
      end
    end
  end

endmodule

// ----- hw/rtl/slt_queue.sv -----
// two-entry queue of line records between tracker and steering unit
module slt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slt_pkg::line_rec_t rec_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output slt_pkg::line_rec_t rec_o
);
  import slt_pkg::*;

  line_rec_t   mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rec_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/slt_back.sv -----
// steering unit: centre error, pd steering or reverse, motor conversion, output register
module slt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slt_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  slt_pkg::line_rec_t rec_i,
  output logic               pop_o,
  slt_res_if.source          res_out
);
  import slt_pkg::*;

  back_state_e state_q, state_d;

  logic                     found_q;
  logic [COL_W-1:0]         start_q;
  logic [COL_W-1:0]         end_q;
  logic signed [DIFF_W-1:0] err_q;
  logic signed [DIFF_W-1:0] de_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ERR_W-1:0]  lve_q;

  logic                      out_valid_q;
  logic                      out_found_q;
  logic [COL_W-1:0]          out_start_q;
  logic [COL_W-1:0]          out_end_q;
  logic [COL_W-1:0]          out_width_q;
  logic signed [ERR_W-1:0]   out_err_q;
  logic signed [MOTOR_W-1:0] out_left_q;
  logic signed [MOTOR_W-1:0] out_right_q;

  logic                     slot_free;
  logic                     load_rec;
  logic                     mul_first;
  logic                     mul_second;
  logic                     finish;
  logic [COL_W:0]           sum_cols;
  logic signed [DIFF_W-1:0] err_raw;
  logic signed [DIFF_W-1:0] err_sat;
  logic signed [DIFF_W-1:0] mul_a;
  logic [GAIN_W-1:0]        mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  rev_base;
  logic signed [STEER_W-1:0] trunc_l;
  logic signed [STEER_W-1:0] trunc_r;
  logic signed [ARG_W-1:0]  arg_l;
  logic signed [ARG_W-1:0]  arg_r;

  assign slot_free = !out_valid_q || res_out.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (!empty_i) state_d = BK_MUL1;
      BK_MUL1:   state_d = found_q ? BK_MUL2 : BK_FINISH;
      BK_MUL2:   state_d = BK_FINISH;
      BK_FINISH: if (slot_free) state_d = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    load_rec   = 1'b0;
    mul_first  = 1'b0;
    mul_second = 1'b0;
    finish     = 1'b0;
    unique case (state_q)
      BK_IDLE:   load_rec   = !empty_i;
      BK_MUL1:   mul_first  = 1'b1;
      BK_MUL2:   mul_second = 1'b1;
      BK_FINISH: finish     = slot_free;
    endcase
  end

  assign pop_o = load_rec;

  // centre error, saturated
  assign sum_cols = {1'b0, rec_i.start_col} + {1'b0, rec_i.end_col};
  assign err_raw  = $signed({2'b00, sum_cols[COL_W:1]}) - $signed({2'b00, cfg_i.center_column});
  always_comb begin
    if (err_raw > ERR_LIMIT) begin
      err_sat = ERR_LIMIT;
    end else if (err_raw < -ERR_LIMIT) begin
      err_sat = -ERR_LIMIT;
    end else begin
      err_sat = err_raw;
    end
  end

  // shared multiplier
  always_comb begin
    if (mul_second) begin
      mul_a = de_q;
      mul_b = cfg_i.d_gain;
    end else if (found_q) begin
      mul_a = err_q;
      mul_b = cfg_i.p_gain;
    end else begin
      mul_a = DIFF_W'(lve_q);
      mul_b = cfg_i.reverse_gain;
    end
  end
  assign prod = PROD_W'(mul_a) * $signed({1'b0, mul_b});

  // drive arguments
  assign rev_base = -$signed({{(ACC_W-SPEED_W-8){1'b0}}, cfg_i.reverse_speed, 8'd0});
  always_comb begin
    if (found_q) begin
      trunc_l = trunc_div256(acc_q);
      trunc_r = trunc_l;
      arg_l   = $signed({{(ARG_W-SPEED_W){1'b0}}, cfg_i.base_speed}) + ARG_W'(trunc_l);
      arg_r   = $signed({{(ARG_W-SPEED_W){1'b0}}, cfg_i.base_speed}) - ARG_W'(trunc_r);
    end else begin
      trunc_l = trunc_div256(rev_base - acc_q);
      trunc_r = trunc_div256(rev_base + acc_q);
      arg_l   = ARG_W'(trunc_l);
      arg_r   = ARG_W'(trunc_r);
    end
  end

  // working registers of the current line
  always_ff @(posedge clk_i) begin
    if (load_rec) begin
      found_q <= rec_i.found;
      start_q <= rec_i.start_col;
      end_q   <= rec_i.end_col;
      err_q   <= err_sat;
      de_q    <= err_sat - DIFF_W'(lve_q);
    end
    if (mul_first) begin
      acc_q <= ACC_W'(prod);
    end else if (mul_second) begin
      acc_q <= acc_q + ACC_W'(prod);
    end
  end

  // sequencer state and last valid error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      lve_q   <= '0;
    end else begin
      state_q <= state_d;
      if (finish && found_q) begin
        lve_q <= err_q[ERR_W-1:0];
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_found_q <= found_q;
      out_start_q <= found_q ? start_q : '0;
      out_end_q   <= found_q ? end_q : '0;
      out_width_q <= found_q ? (end_q - start_q) : '0;
      out_err_q   <= found_q ? err_q[ERR_W-1:0] : '0;
      out_left_q  <= motor_conv(arg_l);
      out_right_q <= motor_conv(arg_r);
    end
  end

  assign res_out.valid       = out_valid_q;
  assign res_out.line_found  = out_found_q;
  assign res_out.run_start   = out_start_q;
  assign res_out.run_end     = out_end_q;
  assign res_out.run_width   = out_width_q;
  assign res_out.line_error  = out_err_q;
  assign res_out.left_motor  = out_left_q;
  assign res_out.right_motor = out_right_q;

endmodule
